// ----- rtl/pctd_pkg.sv -----
package pctd_pkg;

  // Code tree geometry: 31 internal nodes, each holding two 9-bit child fields.
  localparam int NodeCount = 31;
  localparam int NodeW     = 5;
  localparam int ChildW    = 9;
  localparam int EntryW    = 2 * ChildW;
  localparam int LeafBit   = 8;
  localparam int CharW     = 8;
  localparam int StepW     = 3;
  localparam int SymBits   = 5;

  localparam logic [CharW-1:0] CharNewline = 8'h0A;

  // One result transaction as it travels to the output queue.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } pctd_res_t;

  // Child field of a leaf: flag set, character in the low byte.
  function automatic logic [ChildW-1:0] pctd_leaf(input logic [CharW-1:0] c);
    pctd_leaf = {1'b1, c};
  endfunction

  // Child field of an internal node: flag clear, node index in the low bits.
  function automatic logic [ChildW-1:0] pctd_inner(input logic [NodeW-1:0] n);
    pctd_inner = {{(ChildW-NodeW){1'b0}}, n};
  endfunction

  // Contents of the code tree, one entry per internal node: {one child, zero child}.
  function automatic logic [EntryW-1:0] pctd_tree_entry(input logic [NodeW-1:0] n);
    logic [ChildW-1:0] c0;
    logic [ChildW-1:0] c1;
    c0 = '0;
    c1 = '0;
    case (n)
      5'd0:  begin c0 = pctd_inner(5'd3);  c1 = pctd_inner(5'd1);  end
      5'd1:  begin c0 = pctd_inner(5'd2);  c1 = pctd_inner(5'd21); end
      5'd2:  begin c0 = pctd_inner(5'd9);  c1 = pctd_leaf(8'h20);  end // space
      5'd3:  begin c0 = pctd_inner(5'd4);  c1 = pctd_inner(5'd14); end
      5'd4:  begin c0 = pctd_inner(5'd5);  c1 = pctd_inner(5'd24); end
      5'd5:  begin c0 = pctd_inner(5'd6);  c1 = pctd_leaf(8'h44);  end // D
      5'd6:  begin c0 = pctd_inner(5'd7);  c1 = pctd_inner(5'd8);  end
      5'd7:  begin c0 = pctd_leaf(8'h27);  c1 = pctd_leaf(8'h3F);  end // apostrophe, ?
      5'd8:  begin c0 = pctd_leaf(8'h57);  c1 = pctd_leaf(8'h2C);  end // W, comma
      5'd9:  begin c0 = pctd_leaf(8'h52);  c1 = pctd_inner(5'd10); end // R
      5'd10: begin c0 = pctd_inner(5'd11); c1 = pctd_inner(5'd18); end
      5'd11: begin c0 = pctd_inner(5'd12); c1 = pctd_leaf(8'h41);  end // A
      5'd12: begin c0 = pctd_inner(5'd13); c1 = pctd_inner(5'd30); end
      5'd13: begin c0 = pctd_leaf(8'h5A);  c1 = pctd_leaf(8'h2D);  end // Z, -
      5'd14: begin c0 = pctd_inner(5'd15); c1 = pctd_inner(5'd22); end
      5'd15: begin c0 = pctd_inner(5'd16); c1 = pctd_leaf(8'h43);  end // C
      5'd16: begin c0 = pctd_inner(5'd17); c1 = pctd_leaf(8'h46);  end // F
      5'd17: begin c0 = pctd_leaf(8'h48);  c1 = pctd_leaf(8'h2E);  end // H, full stop
      5'd18: begin c0 = pctd_inner(5'd19); c1 = pctd_inner(5'd26); end
      5'd19: begin c0 = pctd_inner(5'd23); c1 = pctd_inner(5'd20); end
      5'd20: begin c0 = pctd_leaf(8'h42);  c1 = pctd_leaf(8'h47);  end // B, G
      5'd21: begin c0 = pctd_leaf(8'h45);  c1 = pctd_leaf(8'h50);  end // E, P
      5'd22: begin c0 = pctd_leaf(8'h4B);  c1 = pctd_leaf(8'h49);  end // K, I
      5'd23: begin c0 = pctd_leaf(8'h4A);  c1 = pctd_leaf(8'h4D);  end // J, M
      5'd24: begin c0 = pctd_inner(5'd25); c1 = pctd_inner(5'd28); end
      5'd25: begin c0 = pctd_leaf(8'h4C);  c1 = pctd_leaf(8'h4F);  end // L, O
      5'd26: begin c0 = pctd_inner(5'd29); c1 = pctd_inner(5'd27); end
      5'd27: begin c0 = pctd_leaf(8'h4E);  c1 = pctd_leaf(8'h51);  end // N, Q
      5'd28: begin c0 = pctd_leaf(8'h53);  c1 = pctd_leaf(8'h54);  end // S, T
      5'd29: begin c0 = pctd_leaf(8'h55);  c1 = pctd_leaf(8'h56);  end // U, V
      5'd30: begin c0 = pctd_leaf(8'h58);  c1 = pctd_leaf(8'h59);  end // X, Y
      default: begin c0 = '0; c1 = '0; end
    endcase
    pctd_tree_entry = {c1, c0};
  endfunction

  // Position of a character in the alphabet A-Z, space . , - ' ?; anything else walks as zero.
  function automatic logic [SymBits-1:0] pctd_char_index(input logic [CharW-1:0] sym);
    logic [CharW-1:0] off;
    off = sym - 8'h41;
    if (sym >= 8'h41 && sym <= 8'h5A) begin
      pctd_char_index = off[SymBits-1:0];
    end else begin
      case (sym)
        8'h20:   pctd_char_index = 5'd26;
        8'h2E:   pctd_char_index = 5'd27;
        8'h2C:   pctd_char_index = 5'd28;
        8'h2D:   pctd_char_index = 5'd29;
        8'h27:   pctd_char_index = 5'd30;
        8'h3F:   pctd_char_index = 5'd31;
        default: pctd_char_index = 5'd0;
      endcase
    end
  endfunction

endpackage

// ----- rtl/prefix_code_text_decoder.sv -----
// Prefix-code text decoder. Each input transaction carries one character byte; letters A-Z,
// space, full stop, comma, hyphen, apostrophe and question mark give a 5-bit code, any other
// byte is walked as 00000, and the code is fed most significant bit first through a fixed
// prefix-code tree held in a 31-entry RAM. Every leaf reached produces one output transaction
// (decoded character in tdata), so a character yields zero, one or two results; tlast marks
// the final result caused by that character. A newline (0x0A) produces a newline result with
// tlast set and returns the walk to the root, dropping any partial code. A newline is handled
// in its accept step; any other character takes an accept step and five tree steps, each one
// read of the single RAM port, plus a flush step when it decodes two characters and the
// second on its final bit. A step with a result waits while the output queue is full.
// After reset a load pass fills all 31 tree RAM entries, during which no input is accepted.
// A two-entry output queue lets the next character be taken while results still wait downstream.
module prefix_code_text_decoder
  import pctd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tlast_o
);

  logic      push_valid;
  logic      push_ready;
  pctd_res_t push_res;
  pctd_res_t out_res;

  // Tree walk engine with its code tree RAM.
  pctd_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_symbol_i  (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_o       (push_res),
    .push_ready_i (push_ready)
  );

  // Output queue decoupling the walk from the result stream.
  pctd_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push_res),
    .push_ready_o (push_ready),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (out_res)
  );

  assign m_axis_tdata_o = out_res.ch;
  assign m_axis_tlast_o = out_res.last;

endmodule

// ----- rtl/pctd_ram.sv -----
module pctd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pctd_walker.sv -----
module pctd_walker
  import pctd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] in_symbol_i,
  output logic             push_valid_o,
  output pctd_res_t        push_o,
  input  logic             push_ready_i
);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StWalk  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [NodeW-1:0]   node_q, node_d;
  logic [NodeW-1:0]   load_addr_q, load_addr_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               pend_valid_q, pend_valid_d;
  logic [CharW-1:0]   pend_char_q, pend_char_d;
  logic [SymBits-1:0] sh_q, sh_d;

  logic               ram_we;
  logic [EntryW-1:0]  ram_wdata;
  logic               ram_re;
  logic [NodeW-1:0]   ram_raddr;
  logic [EntryW-1:0]  rd_entry;

  logic [ChildW-1:0]  child;
  logic               is_leaf;
  logic [NodeW-1:0]   next_node;
  logic               last_step;
  logic               need_push;
  logic               is_newline;

  // Code tree store, filled from the constant table after reset.
  pctd_ram #(
    .Width (EntryW),
    .Depth (NodeCount)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  // Child selection for the current bit of the code.
  assign child      = sh_q[SymBits-1] ? rd_entry[EntryW-1:ChildW] : rd_entry[ChildW-1:0];
  assign is_leaf    = child[LeafBit];
  assign next_node  = (is_leaf || child[NodeW-1:0] >= NodeW'(NodeCount)) ? '0
                                                                          : child[NodeW-1:0];
  assign last_step  = step_q == StepW'(SymBits - 1);
  assign need_push  = is_leaf ? (pend_valid_q || last_step) : (last_step && pend_valid_q);
  assign is_newline = in_symbol_i == CharNewline;
  assign ram_wdata  = pctd_tree_entry(load_addr_q);

  // Load sweep, then one tree step per cycle while walking, unless a result waits on a full output queue.
  always_comb begin
    state_d      = state_q;
    node_d       = node_q;
    load_addr_d  = load_addr_q;
    step_d       = step_q;
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    sh_d         = sh_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = node_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    push_o       = '0;
    case (state_q)
      StLoad: begin
        ram_we = 1'b1;
        if (load_addr_q == NodeW'(NodeCount - 1)) begin
          state_d = StIdle;
        end else begin
          load_addr_d = load_addr_q + 1'b1;
        end
      end
      StIdle: begin
        in_ready_o = push_ready_i;
        if (in_valid_i && push_ready_i) begin
          if (is_newline) begin
            push_valid_o = 1'b1;
            push_o       = '{ch: CharNewline, last: 1'b1};
            node_d       = '0;
          end else begin
            sh_d      = pctd_char_index(in_symbol_i);
            step_d    = '0;
            ram_re    = 1'b1;
            ram_raddr = node_q;
            state_d   = StWalk;
          end
        end
      end
      StWalk: begin
        if (!need_push || push_ready_i) begin
          node_d = next_node;
          sh_d   = sh_q << 1;
          step_d = step_q + 1'b1;
          if (is_leaf) begin
            if (pend_valid_q) begin
              push_valid_o = 1'b1;
              push_o       = '{ch: pend_char_q, last: 1'b0};
              pend_char_d  = child[CharW-1:0];
              if (last_step) begin
                state_d = StFlush;
              end
            end else if (last_step) begin
              push_valid_o = 1'b1;
              push_o       = '{ch: child[CharW-1:0], last: 1'b1};
              state_d      = StIdle;
            end else begin
              pend_valid_d = 1'b1;
              pend_char_d  = child[CharW-1:0];
            end
          end else if (last_step) begin
            if (pend_valid_q) begin
              push_valid_o = 1'b1;
              push_o       = '{ch: pend_char_q, last: 1'b1};
              pend_valid_d = 1'b0;
            end
            state_d = StIdle;
          end
          if (!last_step) begin
            ram_re    = 1'b1;
            ram_raddr = next_node;
          end
        end
      end
      StFlush: begin
        if (push_ready_i) begin
          push_valid_o = 1'b1;
          push_o       = '{ch: pend_char_q, last: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      node_q       <= '0;
      load_addr_q  <= '0;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_q       <= node_d;
      load_addr_q  <= load_addr_d;
      step_q       <= step_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    sh_q        <= sh_d;
  end

  // A character is only taken once the tree is loaded and the last walk is finished.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (state_q == StIdle && !pend_valid_q))
    else $error("input transaction taken outside the idle state");

  // A result is never offered to a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> push_ready_i)
    else $error("result pushed while the output queue is full");

  // The flush state exists only to deliver a held character.
  a_flush_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFlush) |-> pend_valid_q)
    else $error("flush state entered without a held character");

  // The walk position always names an existing node.
  a_node_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_q < NodeW'(NodeCount))
    else $error("tree node index out of range");

endmodule

// ----- rtl/pctd_outq.sv -----
module pctd_outq
  import pctd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  pctd_res_t        push_i,
  output logic             push_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pctd_res_t        out_o
);

  pctd_res_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = count_q != 2'd2;
  assign out_valid_o  = count_q != 2'd0;
  assign out_o        = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = out_valid_o && out_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

endmodule
